>>> sv/rstree_pkg.sv
`default_nettype none
package rstree_pkg;

  // fixed field widths of the channels
  localparam int FIELD_W = 12;
  localparam int VIDX_W  = 5;
  localparam int COST_W  = 21;
  localparam int TOTAL_W = 26;

  // sign codes
  localparam logic [1:0] SIGN_POS = 2'd0;
  localparam logic [1:0] SIGN_NEG = 2'd1;

  typedef struct packed {
    logic [FIELD_W-1:0] row;
    logic [FIELD_W-1:0] column;
    logic [1:0]         sign;
    logic               border_present;
    logic [FIELD_W-1:0] border_row;
    logic [FIELD_W-1:0] border_column;
    logic               final_vertex;
  } load_item_t;

  typedef struct packed {
    logic               edge_valid;
    logic [VIDX_W-1:0]  from_vertex;
    logic [VIDX_W-1:0]  to_vertex;
    logic               to_border;
    logic [COST_W-1:0]  edge_cost;
    logic [TOTAL_W-1:0] total_cost;
    logic               overflow;
    logic               last_edge;
  } tree_item_t;

  // controller to datapath
  typedef struct packed {
    logic accept_en;
    logic run_start;
    logic bscan_start;
    logic pscan_start;
    logic take;
    logic relab_start;
    logic emit;
    logic emit_last;
    logic emit_empty;
    logic clear_set;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic final_in;
    logic unbalanced;
    logic scan_busy;
    logic relab_busy;
    logic sqrt_busy;
    logic found;
    logic pend_valid;
    logic at_target;
    logic out_free;
  } ctrl_sts_t;

endpackage
`default_nettype wire

>>> sv/rstree_stream_if.sv
`default_nettype none
interface rstree_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> sv/rstree_isqrt.sv
`default_nettype none
module rstree_isqrt #(
  parameter int RAD_W = 41
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire logic [RAD_W-1:0]       radicand,
  output logic                        busy,
  output logic [(RAD_W+1)/2-1:0]      root
);
  localparam int SQN   = (RAD_W + 1) / 2;
  localparam int REM_W = SQN + 2;
  localparam int CNT_W = $clog2(SQN + 1);

  logic [2*SQN-1:0] rad;
  logic [REM_W-1:0] rem;
  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  logic [CNT_W-1:0] cnt;

  // one result bit per cycle, restoring form
  always_comb begin
    rem_sh = {rem[SQN-1:0], rad[2*SQN-1 -: 2]};
    trial  = {root, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(SQN);
      rad  <= (2*SQN)'(radicand);
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad <= {rad[2*SQN-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem  <= rem_sh - trial;
        root <= {root[SQN-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[SQN-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

>>> sv/rstree_ctrl.sv
`default_nettype none
module rstree_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire rstree_pkg::ctrl_sts_t sts,
  output rstree_pkg::ctrl_cmd_t      cmd
);
  import rstree_pkg::*;

  localparam logic [3:0] S_LOAD   = 4'd0;
  localparam logic [3:0] S_START  = 4'd1;
  localparam logic [3:0] S_BSCAN  = 4'd2;
  localparam logic [3:0] S_PSCAN  = 4'd3;
  localparam logic [3:0] S_DECIDE = 4'd4;
  localparam logic [3:0] S_EMIT   = 4'd5;
  localparam logic [3:0] S_TAKE   = 4'd6;
  localparam logic [3:0] S_SQRT   = 4'd7;
  localparam logic [3:0] S_RELAB  = 4'd8;
  localparam logic [3:0] S_FIN    = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_LOAD: begin
        cmd.accept_en = 1'b1;
        if (sts.final_in) begin
          state_next = S_START;
        end
      end
      S_START: begin
        cmd.run_start = 1'b1;
        if (sts.unbalanced) begin
          cmd.bscan_start = 1'b1;
          state_next      = S_BSCAN;
        end else begin
          cmd.pscan_start = 1'b1;
          state_next      = S_PSCAN;
        end
      end
      S_BSCAN: begin
        if (!sts.scan_busy) begin
          cmd.pscan_start = 1'b1;
          state_next      = S_PSCAN;
        end
      end
      S_PSCAN: begin
        if (!sts.scan_busy) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (!sts.found) begin
          state_next = S_FIN;
        end else if (sts.pend_valid) begin
          state_next = S_EMIT;
        end else begin
          state_next = S_TAKE;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_TAKE;
        end
      end
      S_TAKE: begin
        cmd.take   = 1'b1;
        state_next = S_SQRT;
      end
      S_SQRT: begin
        if (!sts.sqrt_busy) begin
          if (sts.at_target) begin
            state_next = S_FIN;
          end else begin
            cmd.relab_start = 1'b1;
            state_next      = S_RELAB;
          end
        end
      end
      S_RELAB: begin
        if (!sts.relab_busy) begin
          cmd.pscan_start = 1'b1;
          state_next      = S_PSCAN;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          if (sts.pend_valid) begin
            cmd.emit      = 1'b1;
            cmd.emit_last = 1'b1;
          end else begin
            cmd.emit_empty = 1'b1;
          end
          cmd.clear_set = 1'b1;
          state_next    = S_LOAD;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end
endmodule
`default_nettype wire

>>> sv/rstree_dp.sv
`default_nettype none
module rstree_dp #(
  parameter int MAX_VERTICES = 32,
  parameter int COORD_BITS   = 12
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  rstree_stream_if.sink              load,
  rstree_stream_if.source            tree,
  input  wire rstree_pkg::ctrl_cmd_t cmd,
  output rstree_pkg::ctrl_sts_t      sts
);
  import rstree_pkg::*;

  localparam int VW    = $clog2(MAX_VERTICES);
  localparam int CW    = $clog2(MAX_VERTICES + 1);
  localparam int LW    = $clog2(2 * MAX_VERTICES);
  localparam int C     = COORD_BITS;
  localparam int D2W   = 2 * COORD_BITS + 1;
  localparam int RAD_W = D2W + 16;
  localparam int SQN   = (RAD_W + 1) / 2;

  // residue store
  logic [C-1:0]   mem_row [MAX_VERTICES];
  logic [C-1:0]   mem_col [MAX_VERTICES];
  logic [2*C:0]   mem_bp  [MAX_VERTICES];
  logic [LW-1:0]  mem_lab [MAX_VERTICES];

  logic [CW-1:0]  vcount;
  logic [CW-1:0]  pcount;
  logic [CW-1:0]  ncount;
  logic           dropped;
  logic           take_in;
  logic           has_room;
  logic [VW-1:0]  widx;
  logic [VW-1:0]  nlast;

  // read ports
  logic [VW-1:0]  ra;
  logic [VW-1:0]  rb;
  logic [C-1:0]   rda_row;
  logic [C-1:0]   rda_col;
  logic [2*C:0]   rda_bp;
  logic [C-1:0]   rdb_row;
  logic [C-1:0]   rdb_col;
  logic [LW-1:0]  lab_a;
  logic [LW-1:0]  lab_b;

  // label write port
  logic           lab_we;
  logic [VW-1:0]  lab_wa;
  logic [LW-1:0]  lab_wd;

  // scan sequencer and pipeline
  logic           scan_issue;
  logic           scan_border;
  logic [VW-1:0]  si;
  logic [VW-1:0]  sj;
  logic           p1_v;
  logic           p1_border;
  logic [VW-1:0]  p1_i;
  logic [VW-1:0]  p1_j;
  logic           p2_v;
  logic           p2_border;
  logic           p2_ok;
  logic [VW-1:0]  p2_i;
  logic [VW-1:0]  p2_j;
  logic [2*C-1:0] sq1;
  logic [2*C-1:0] sq2;
  logic [C-1:0]   bx;
  logic [C-1:0]   by;
  logic [C-1:0]   dx;
  logic [C-1:0]   dy;
  logic [D2W-1:0] d2;

  // best candidates
  logic           best_v;
  logic [D2W-1:0] best_d2;
  logic [VW-1:0]  best_i;
  logic [VW-1:0]  best_j;
  logic           bb_v;
  logic [D2W-1:0] bb_d2;
  logic [VW-1:0]  bb_i;
  logic           pick_border;

  // chosen edge and relabel sweep
  logic           pend_v;
  logic [VW-1:0]  pend_i;
  logic [VW-1:0]  pend_j;
  logic           pend_border;
  logic [CW-1:0]  kcnt;
  logic [CW-1:0]  target;
  logic           rl_fetch;
  logic           rl_grab;
  logic           rl_issue;
  logic [VW-1:0]  rl_cnt;
  logic           rl_v;
  logic [VW-1:0]  rl_j;
  logic [LW-1:0]  g1;
  logic [LW-1:0]  g2;

  // square root and output
  logic           sqrt_busy;
  logic [SQN-1:0] root;
  logic [D2W-1:0] take_d2;
  logic [COST_W-1:0]  cost;
  logic [TOTAL_W-1:0] total;
  logic [TOTAL_W-1:0] total_next;
  logic           out_v;
  tree_item_t     out_q;
  logic           out_free;

  assign load.ready = cmd.accept_en;
  assign take_in    = load.valid & cmd.accept_en;
  assign has_room   = vcount < CW'(MAX_VERTICES);
  assign widx       = vcount[VW-1:0];
  assign nlast      = VW'(vcount - 1'b1);

  // load residues and count signs
  always_ff @(posedge clk) begin
    if (rst) begin
      vcount  <= '0;
      pcount  <= '0;
      ncount  <= '0;
      dropped <= 1'b0;
    end else if (cmd.clear_set) begin
      vcount  <= '0;
      pcount  <= '0;
      ncount  <= '0;
      dropped <= 1'b0;
    end else if (take_in) begin
      if (has_room) begin
        vcount <= vcount + 1'b1;
        if (load.data.sign == SIGN_POS) begin
          pcount <= pcount + 1'b1;
        end else if (load.data.sign == SIGN_NEG) begin
          ncount <= ncount + 1'b1;
        end
      end else begin
        dropped <= 1'b1;
      end
    end
  end

  // coordinate store writes
  always_ff @(posedge clk) begin
    if (take_in && has_room) begin
      mem_row[widx] <= C'(load.data.row);
      mem_col[widx] <= C'(load.data.column);
      mem_bp[widx]  <= {load.data.border_present, C'(load.data.border_row),
                        C'(load.data.border_column)};
    end
  end

  // label store: initial label on load, relabel during the sweep
  always_comb begin
    lab_we = 1'b0;
    lab_wa = rl_j;
    lab_wd = g2;
    if (take_in && has_room) begin
      lab_we = 1'b1;
      lab_wa = widx;
      lab_wd = LW'(widx);
    end else if (rl_v && (lab_a == g1)) begin
      lab_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (lab_we) begin
      mem_lab[lab_wa] <= lab_wd;
    end
  end

  // registered reads
  always_comb begin
    if (rl_fetch) begin
      ra = pend_i;
      rb = pend_j;
    end else if (rl_issue) begin
      ra = rl_cnt;
      rb = sj;
    end else begin
      ra = si;
      rb = sj;
    end
  end

  always_ff @(posedge clk) begin
    rda_row <= mem_row[ra];
    rda_col <= mem_col[ra];
    rda_bp  <= mem_bp[ra];
    rdb_row <= mem_row[rb];
    rdb_col <= mem_col[rb];
    lab_a   <= mem_lab[ra];
    lab_b   <= mem_lab[rb];
  end

  // scan address sequencer: border sweep over i, pair sweep over i < j
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_issue <= 1'b0;
    end else if (cmd.bscan_start) begin
      scan_issue  <= vcount != '0;
      scan_border <= 1'b1;
      si          <= '0;
      sj          <= '0;
    end else if (cmd.pscan_start) begin
      scan_issue  <= vcount >= CW'(2);
      scan_border <= 1'b0;
      si          <= '0;
      sj          <= VW'(1);
    end else if (scan_issue) begin
      if (scan_border) begin
        if (si == nlast) begin
          scan_issue <= 1'b0;
        end else begin
          si <= si + 1'b1;
        end
      end else if (sj == nlast) begin
        if (si == nlast - 1'b1) begin
          scan_issue <= 1'b0;
        end else begin
          si <= si + 1'b1;
          sj <= si + VW'(2);
        end
      end else begin
        sj <= sj + 1'b1;
      end
    end
  end

  // distance pipeline tags
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v <= 1'b0;
      p2_v <= 1'b0;
    end else begin
      p1_v <= scan_issue;
      p2_v <= p1_v;
    end
  end

  always_comb begin
    bx = p1_border ? rda_bp[2*C-1:C] : rdb_row;
    by = p1_border ? rda_bp[C-1:0] : rdb_col;
    dx = (rda_row > bx) ? rda_row - bx : bx - rda_row;
    dy = (rda_col > by) ? rda_col - by : by - rda_col;
  end

  // squares registered before the sum
  always_ff @(posedge clk) begin
    p1_border <= scan_border;
    p1_i      <= si;
    p1_j      <= sj;
    p2_border <= p1_border;
    p2_i      <= p1_i;
    p2_j      <= p1_j;
    p2_ok     <= p1_border ? rda_bp[2*C] : (lab_a != lab_b);
    sq1       <= dx * dx;
    sq2       <= dy * dy;
  end

  assign d2 = D2W'(sq1) + D2W'(sq2);

  // cheapest cross-group pair or border edge, pair or earlier on ties
  assign pick_border = bb_v && (!best_v || (bb_d2 < best_d2));
  assign take_d2     = pick_border ? bb_d2 : best_d2;

  always_ff @(posedge clk) begin
    if (rst) begin
      best_v <= 1'b0;
      bb_v   <= 1'b0;
    end else begin
      if (cmd.pscan_start) begin
        best_v <= 1'b0;
      end else if (p2_v && !p2_border && p2_ok && (!best_v || (d2 < best_d2))) begin
        best_v  <= 1'b1;
        best_d2 <= d2;
        best_i  <= p2_i;
        best_j  <= p2_j;
      end
      if (cmd.run_start) begin
        bb_v <= 1'b0;
      end else if (cmd.take && pick_border) begin
        bb_v <= 1'b0;
      end else if (p2_v && p2_border && p2_ok && (!bb_v || (d2 < bb_d2))) begin
        bb_v  <= 1'b1;
        bb_d2 <= d2;
        bb_i  <= p2_i;
      end
    end
  end

  // chosen edge and tree size
  assign target = (pcount != ncount) ? vcount : vcount - 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_v <= 1'b0;
      kcnt   <= '0;
    end else begin
      if (cmd.run_start) begin
        kcnt <= '0;
      end else if (cmd.take) begin
        kcnt <= kcnt + 1'b1;
      end
      if (cmd.take) begin
        pend_v      <= 1'b1;
        pend_i      <= pick_border ? bb_i : best_i;
        pend_j      <= pick_border ? bb_i : best_j;
        pend_border <= pick_border;
      end else if (cmd.emit || cmd.clear_set) begin
        pend_v <= 1'b0;
      end
    end
  end

  // relabel: fetch both end labels, then sweep every vertex
  always_ff @(posedge clk) begin
    if (rst) begin
      rl_fetch <= 1'b0;
      rl_grab  <= 1'b0;
      rl_issue <= 1'b0;
      rl_v     <= 1'b0;
    end else begin
      rl_fetch <= cmd.relab_start;
      rl_grab  <= rl_fetch;
      rl_v     <= rl_issue;
      if (rl_grab) begin
        rl_issue <= 1'b1;
        rl_cnt   <= '0;
      end else if (rl_issue) begin
        if (rl_cnt == nlast) begin
          rl_issue <= 1'b0;
        end else begin
          rl_cnt <= rl_cnt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    rl_j <= rl_cnt;
    if (rl_grab) begin
      g1 <= lab_a;
      g2 <= pend_border ? LW'(vcount) + LW'(pend_i) : lab_b;
    end
  end

  // edge length
  rstree_isqrt #(
    .RAD_W (RAD_W)
  ) u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.take),
    .radicand ({take_d2, 16'd0}),
    .busy     (sqrt_busy),
    .root     (root)
  );

  assign cost       = COST_W'(root);
  assign total_next = total + TOTAL_W'(cost);

  // output register
  assign out_free   = !out_v || tree.ready;
  assign tree.valid = out_v;
  assign tree.data  = out_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (cmd.emit || cmd.emit_empty) begin
      out_v <= 1'b1;
    end else if (tree.ready) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.run_start) begin
      total <= '0;
    end else if (cmd.emit) begin
      total <= total_next;
    end
    if (cmd.emit) begin
      out_q.edge_valid  <= 1'b1;
      out_q.from_vertex <= VIDX_W'(pend_i);
      out_q.to_vertex   <= VIDX_W'(pend_j);
      out_q.to_border   <= pend_border;
      out_q.edge_cost   <= cost;
      out_q.total_cost  <= total_next;
      out_q.overflow    <= dropped;
      out_q.last_edge   <= cmd.emit_last;
    end else if (cmd.emit_empty) begin
      out_q.edge_valid  <= 1'b0;
      out_q.from_vertex <= '0;
      out_q.to_vertex   <= '0;
      out_q.to_border   <= 1'b0;
      out_q.edge_cost   <= '0;
      out_q.total_cost  <= '0;
      out_q.overflow    <= dropped;
      out_q.last_edge   <= 1'b1;
    end
  end

  // status
  always_comb begin
    sts            = '0;
    sts.final_in   = load.valid & load.data.final_vertex;
    sts.unbalanced = pcount != ncount;
    sts.scan_busy  = scan_issue | p1_v | p2_v;
    sts.relab_busy = rl_fetch | rl_grab | rl_issue | rl_v;
    sts.sqrt_busy  = sqrt_busy;
    sts.found      = best_v | bb_v;
    sts.pend_valid = pend_v;
    sts.at_target  = kcnt == target;
    sts.out_free   = out_free;
  end
endmodule
`default_nettype wire

>>> sv/residue_spanning_tree.sv
// channel  dir  payload      handshake
// load     in   load_item_t  valid/ready, one residue per item
// tree     out  tree_item_t  valid/ready, one tree edge per item
//
// Ready is low from the final load until the last edge of the run (or an
// empty result item) has been handed to the output register.
// A run takes a border sweep when the sign counts differ, then per chosen
// edge a pair sweep, a square root and a relabel sweep. The pair sweep
// through the two-port residue store dominates the run time.
// Reset (rst, synchronous) empties the set; stalls on tree hold the run.
`default_nettype none
module residue_spanning_tree #(
  parameter int MAX_VERTICES = 32,
  parameter int COORD_BITS   = 12
) (
  input wire logic        clk,
  input wire logic        rst,
  rstree_stream_if.sink   load,
  rstree_stream_if.source tree
);
  import rstree_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  rstree_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  rstree_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_BITS   (COORD_BITS)
  ) u_dp (
    .clk  (clk),
    .rst  (rst),
    .load (load),
    .tree (tree),
    .cmd  (cmd),
    .sts  (sts)
  );
endmodule
`default_nettype wire
